// File: hdl/mi4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants, command types and the cofactor term table for the
// 4x4 adjugate matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIM       = 4;
    localparam int CELLS     = DIM * DIM;
    localparam int ENTRY_W   = 32;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int CNT_W     = IDX_W + 1;
    // cofactor: six triple products of 32-bit entries, below 2^96 in magnitude
    localparam int COF_W     = 97;
    localparam int MAG_W     = COF_W - 1;
    // determinant below 2^130 in magnitude
    localparam int ACC_W     = 132;
    localparam int DEN_W     = ACC_W - 2;
    localparam int REM_W     = DEN_W + 1;
    localparam int NUM_W     = MAG_W + 2 * FRAC_BITS;
    localparam int DCNT_W    = $clog2(NUM_W);
    localparam int Q_HI_STEPS = NUM_W - ENTRY_W;
    localparam int OUT_DATA_W = 40;
    localparam int TERMS     = 6;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_WRITE,
        OP_LOAD_X_MAT,
        OP_MUL_X,
        OP_MAC,
        OP_STORE_COF,
        OP_LOAD_X_COF,
        OP_STORE_DET,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [1:0]       limb;
        logic             sub;
        logic             hi;
        logic             last;
    } cmd_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_LDA,
        S_MULB,
        S_LIMB,
        S_STORE,
        S_DLD,
        S_DLIMB,
        S_DET,
        S_DIVINIT,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             neg;
    } term_t;

    // Term t of the signed cofactor feeding adjugate entry k (k = r*4 + c,
    // which is the cofactor of element row c, column r).
    function automatic term_t cof_term(input logic [IDX_W-1:0] k, input logic [2:0] t);
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] rr [0:2];
        logic [1:0] cc [0:2];
        logic [1:0] j0;
        logic [1:0] j1;
        logic [1:0] j2;
        logic       neg;
        term_t      res;
        row = k[1:0];
        col = k[3:2];
        rr[0] = (row == 2'd0) ? 2'd1 : 2'd0;
        rr[1] = (row <= 2'd1) ? 2'd2 : 2'd1;
        rr[2] = (row <= 2'd2) ? 2'd3 : 2'd2;
        cc[0] = (col == 2'd0) ? 2'd1 : 2'd0;
        cc[1] = (col <= 2'd1) ? 2'd2 : 2'd1;
        cc[2] = (col <= 2'd2) ? 2'd3 : 2'd2;
        case (t)
            3'd0: begin j0 = 2'd0; j1 = 2'd1; j2 = 2'd2; neg = 1'b0; end
            3'd1: begin j0 = 2'd0; j1 = 2'd2; j2 = 2'd1; neg = 1'b1; end
            3'd2: begin j0 = 2'd1; j1 = 2'd0; j2 = 2'd2; neg = 1'b1; end
            3'd3: begin j0 = 2'd1; j1 = 2'd2; j2 = 2'd0; neg = 1'b0; end
            3'd4: begin j0 = 2'd2; j1 = 2'd0; j2 = 2'd1; neg = 1'b0; end
            3'd5: begin j0 = 2'd2; j1 = 2'd1; j2 = 2'd0; neg = 1'b1; end
            default: begin j0 = 2'd0; j1 = 2'd1; j2 = 2'd2; neg = 1'b0; end
        endcase
        res.a   = {rr[0], cc[j0]};
        res.b   = {rr[1], cc[j1]};
        res.c   = {rr[2], cc[j2]};
        res.neg = neg ^ row[0] ^ col[0];
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hdl/mi4_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: load counting, cofactor and determinant accumulation steps,
// division steps and result handshake.
// ----------------------------------------------------------------------------
module mi4_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          first_entry,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output mi4_pkg::cmd_t      cmd
);
    import mi4_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [2:0]          t_reg, t_next;
    logic [1:0]          limb_reg, limb_next;
    logic [DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]    base_cnt;
    logic [CNT_W-1:0]    cnt_inc;
    term_t               term;

    assign term     = cof_term(k_reg, t_reg);
    assign base_cnt = first_entry ? CNT_W'(0) : load_cnt_reg;
    assign cnt_inc  = base_cnt + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            k_reg        <= '0;
            t_reg        <= '0;
            limb_reg     <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            t_reg        <= t_next;
            limb_reg     <= limb_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        limb_next     = limb_reg;
        div_cnt_next  = div_cnt_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        cmd.op        = OP_IDLE;
        cmd.idx       = k_reg;
        cmd.limb      = limb_reg;
        cmd.sub       = 1'b0;
        cmd.hi        = 1'b0;
        cmd.last      = (k_reg == IDX_W'(CELLS - 1));
        unique case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                cmd.idx  = base_cnt[IDX_W-1:0];
                if (s_tvalid)
                begin
                    cmd.op = OP_WRITE;
                    if (cnt_inc == CNT_W'(CELLS))
                    begin
                        load_cnt_next = '0;
                        k_next        = '0;
                        t_next        = '0;
                        limb_next     = '0;
                        state_next    = S_LDA;
                    end
                    else
                    begin
                        load_cnt_next = cnt_inc;
                    end
                end
            end
            S_LDA:
            begin
                cmd.op     = OP_LOAD_X_MAT;
                cmd.idx    = term.a;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.op     = OP_MUL_X;
                cmd.idx    = term.b;
                limb_next  = '0;
                state_next = S_LIMB;
            end
            S_LIMB:
            begin
                cmd.op  = OP_MAC;
                cmd.idx = term.c;
                cmd.sub = term.neg;
                if (limb_reg == 2'd2)
                begin
                    limb_next = '0;
                    if (t_reg == 3'(TERMS - 1))
                    begin
                        t_next     = '0;
                        state_next = S_STORE;
                    end
                    else
                    begin
                        t_next     = t_reg + 3'd1;
                        state_next = S_LDA;
                    end
                end
                else
                begin
                    limb_next = limb_reg + 2'd1;
                end
            end
            S_STORE:
            begin
                cmd.op = OP_STORE_COF;
                if (k_reg == IDX_W'(CELLS - 1))
                begin
                    k_next     = '0;
                    state_next = S_DLD;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_LDA;
                end
            end
            S_DLD:
            begin
                // first-row expansion uses adjugate entries 0, 4, 8 and 12
                cmd.op     = OP_LOAD_X_COF;
                cmd.idx    = {k_reg[1:0], 2'b00};
                limb_next  = '0;
                state_next = S_DLIMB;
            end
            S_DLIMB:
            begin
                cmd.op = OP_MAC;
                if (limb_reg == 2'd2)
                begin
                    limb_next = '0;
                    if (k_reg == IDX_W'(DIM - 1))
                    begin
                        k_next     = '0;
                        state_next = S_DET;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_DLD;
                    end
                end
                else
                begin
                    limb_next = limb_reg + 2'd1;
                end
            end
            S_DET:
            begin
                cmd.op     = OP_STORE_DET;
                k_next     = '0;
                state_next = S_DIVINIT;
            end
            S_DIVINIT:
            begin
                cmd.op       = OP_DIV_INIT;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.op       = OP_DIV_STEP;
                cmd.hi       = (div_cnt_reg < DCNT_W'(Q_HI_STEPS));
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.op     = OP_DIV_FIN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (k_reg == IDX_W'(CELLS - 1))
                    begin
                        k_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_DIVINIT;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output both open");
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg < CNT_W'(CELLS))
        else $error("load count out of range");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg == DCNT_W'(NUM_W - 1)) |=> state_reg == S_FIN)
        else $error("division did not finish");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !m_tready) |=> state_reg == S_OUT)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

// File: hdl/mi4_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi4_datapath
// Matrix and cofactor storage, shared 34x32 multiplier with wide
// accumulator, restoring divider and result registers.
// ----------------------------------------------------------------------------
module mi4_datapath
(
    input  wire logic                   clk,
    input  wire mi4_pkg::cmd_t          cmd,
    input  wire logic [31:0]            entry_value,
    output logic [31:0]                 inv_value,
    output logic [3:0]                  inv_index,
    output logic                        singular,
    output logic                        saturated,
    output logic                        last_entry
);
    import mi4_pkg::*;

    logic [ENTRY_W-1:0]        mat_reg [0:CELLS-1];
    logic [COF_W-1:0]          cof_reg [0:CELLS-1];
    logic [COF_W-1:0]          x_reg, x_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [DEN_W-1:0]          d_reg, d_next;
    logic                      det_neg_reg, det_neg_next;
    logic                      det_zero_reg, det_zero_next;
    logic [NUM_W-1:0]          n_reg, n_next;
    logic [REM_W-1:0]          r_reg, r_next;
    logic [ENTRY_W-1:0]        q_reg, q_next;
    logic                      over_reg, over_next;
    logic                      neg_reg, neg_next;
    logic [31:0]               val_reg, val_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      sing_reg, sing_next;
    logic                      sat_reg, sat_next;
    logic                      last_reg, last_next;

    logic [ENTRY_W-1:0]        mat_rd;
    logic [COF_W-1:0]          cof_rd;
    logic signed [33:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [65:0]        prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   prod_sh;
    logic [ACC_W-1:0]          acc_abs;
    logic [COF_W-1:0]          cof_abs;
    logic [REM_W-1:0]          rem_sh;
    logic                      q_bit;
    logic [31:0]               limit;
    logic                      over_fin;
    logic [31:0]               mag;

    assign mat_rd = mat_reg[cmd.idx];
    assign cof_rd = cof_reg[cmd.idx];
    assign mul_b  = $signed(mat_rd);

    always_comb
    begin
        unique case (cmd.limb)
            2'd0:    mul_a = $signed({2'b00, x_reg[31:0]});
            2'd1:    mul_a = $signed({2'b00, x_reg[63:32]});
            default: mul_a = $signed({x_reg[COF_W-1], x_reg[COF_W-1:64]});
        endcase
        if (cmd.op == OP_MUL_X)
        begin
            mul_a = $signed({{2{x_reg[31]}}, x_reg[31:0]});
        end
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = ACC_W'(prod);
    assign prod_sh  = prod_ext <<< {cmd.limb, 5'b00000};
    assign acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign cof_abs  = cof_rd[COF_W-1] ? (~cof_rd + COF_W'(1)) : cof_rd;
    assign rem_sh   = {r_reg[REM_W-2:0], n_reg[NUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, d_reg});
    assign limit    = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign over_fin = over_reg || (q_reg > limit);
    assign mag      = over_fin ? limit : q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE)
        begin
            mat_reg[cmd.idx] <= entry_value;
        end
        if (cmd.op == OP_STORE_COF)
        begin
            cof_reg[cmd.idx] <= acc_reg[COF_W-1:0];
        end
        x_reg        <= x_next;
        acc_reg      <= acc_next;
        d_reg        <= d_next;
        det_neg_reg  <= det_neg_next;
        det_zero_reg <= det_zero_next;
        n_reg        <= n_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        over_reg     <= over_next;
        neg_reg      <= neg_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        sing_reg     <= sing_next;
        sat_reg      <= sat_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        x_next        = x_reg;
        acc_next      = acc_reg;
        d_next        = d_reg;
        det_neg_next  = det_neg_reg;
        det_zero_next = det_zero_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        over_next     = over_reg;
        neg_next      = neg_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        sing_next     = sing_reg;
        sat_next      = sat_reg;
        last_next     = last_reg;
        unique case (cmd.op)
            OP_IDLE: ;
            OP_WRITE:
            begin
                acc_next = '0;
            end
            OP_LOAD_X_MAT:
            begin
                x_next = {{(COF_W-ENTRY_W){mat_rd[ENTRY_W-1]}}, mat_rd};
            end
            OP_MUL_X:
            begin
                x_next = {{(COF_W-66){prod[65]}}, prod};
            end
            OP_MAC:
            begin
                acc_next = cmd.sub ? acc_reg - prod_sh : acc_reg + prod_sh;
            end
            OP_STORE_COF:
            begin
                acc_next = '0;
            end
            OP_LOAD_X_COF:
            begin
                x_next = cof_rd;
            end
            OP_STORE_DET:
            begin
                det_neg_next  = acc_reg[ACC_W-1];
                det_zero_next = (acc_reg == '0);
                d_next        = acc_abs[DEN_W-1:0];
                acc_next      = '0;
            end
            OP_DIV_INIT:
            begin
                neg_next  = cof_rd[COF_W-1] ^ det_neg_reg;
                n_next    = {cof_abs[MAG_W-1:0], {(2*FRAC_BITS){1'b0}}};
                r_next    = '0;
                q_next    = '0;
                over_next = 1'b0;
            end
            OP_DIV_STEP:
            begin
                r_next    = q_bit ? rem_sh - {1'b0, d_reg} : rem_sh;
                q_next    = {q_reg[ENTRY_W-2:0], q_bit};
                over_next = over_reg | (q_bit & cmd.hi);
                n_next    = {n_reg[NUM_W-2:0], 1'b0};
            end
            OP_DIV_FIN:
            begin
                idx_next  = cmd.idx;
                last_next = cmd.last;
                sing_next = det_zero_reg;
                if (det_zero_reg)
                begin
                    val_next = '0;
                    sat_next = 1'b0;
                end
                else
                begin
                    val_next = neg_reg ? (~mag + 32'd1) : mag;
                    sat_next = over_fin;
                end
            end
            default: ;
        endcase
    end

    assign inv_value  = val_reg;
    assign inv_index  = idx_reg;
    assign singular   = sing_reg;
    assign saturated  = sat_reg;
    assign last_entry = last_reg;

endmodule
`default_nettype wire

// File: hdl/matrix_inverse_4x4.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 matrix inverse by the adjugate method, exact Q16.16 arithmetic.
// Sequence: after the sixteenth input transfer, 96 cofactor terms (load,
//   multiply, three limbs), 16 stores, the determinant accumulation and one
//   determinant store, then per divided entry an init, the 128-step restoring
//   divider and a finish before each result is offered and held until taken.
// Occupancy: one matrix is in work at a time, sharing the divider and the
//   single 34x32 multiplier; the next load starts after the last result.
// Reset: rst_n clears the sequencer and load count; stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] entry_value
    input  wire logic         s_tuser,   // [0] first_entry
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // [31:0] inv_value, [35:32] inv_index
    output logic [1:0]        m_tuser,   // [0] singular, [1] saturated
    output logic              m_tlast    // last_entry
);
    import mi4_pkg::*;

    cmd_t        cmd;
    logic [31:0] inv_value;
    logic [3:0]  inv_index;
    logic        singular;
    logic        saturated;

    mi4_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .first_entry (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd)
    );

    mi4_datapath u_datapath
    (
        .clk         (clk),
        .cmd         (cmd),
        .entry_value (s_tdata),
        .inv_value   (inv_value),
        .inv_index   (inv_index),
        .singular    (singular),
        .saturated   (saturated),
        .last_entry  (m_tlast)
    );

    assign m_tdata = {4'b0000, inv_index, inv_value};
    assign m_tuser = {saturated, singular};

endmodule
`default_nettype wire

// File: verif/matrix_inverse_4x4_chk.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_chk
// Watches both stream channels of the 4x4 inverse, rebuilds each loaded
// matrix, computes the exact adjugate inverse and compares every result
// transfer field by field.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_chk
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending,
    output int               matrices_done,
    output int               singular_seen,
    output int               clipped_seen
);
    import mi4_pkg::*;

    typedef logic signed [199:0] wide_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_entry_t;

    logic [31:0] entries [0:CELLS-1];
    int unsigned entries_loaded;
    inv_entry_t  inverse_q [$];

    function automatic wide_t sx(input logic [31:0] v);
        return wide_t'($signed(v));
    endfunction

    // signed cofactor of element (row, col)
    function automatic wide_t cofactor_of(input int row, input int col);
        wide_t e [0:2][0:2];
        wide_t s;
        int er;
        int ec;
        er = 0;
        for (int r = 0; r < DIM; r++)
        begin
            if (r != row)
            begin
                ec = 0;
                for (int c = 0; c < DIM; c++)
                begin
                    if (c != col)
                    begin
                        e[er][ec] = sx(entries[r*DIM + c]);
                        ec++;
                    end
                end
                er++;
            end
        end
        s = e[0][0]*e[1][1]*e[2][2] - e[0][0]*e[1][2]*e[2][1]
          - e[0][1]*e[1][0]*e[2][2] + e[0][1]*e[1][2]*e[2][0]
          + e[0][2]*e[1][0]*e[2][1] - e[0][2]*e[1][1]*e[2][0];
        return ((row + col) % 2 == 1) ? -s : s;
    endfunction

    task automatic predict_inverse();
        wide_t adj [0:CELLS-1];
        wide_t det;
        wide_t q;
        inv_entry_t x;
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
                adj[r*DIM + c] = cofactor_of(c, r);
        det = 0;
        for (int c = 0; c < DIM; c++)
            det = det + adj[c*DIM] * sx(entries[c]);
        for (int k = 0; k < CELLS; k++)
        begin
            x.index     = 4'(k);
            x.singular  = (det == 0);
            x.saturated = 1'b0;
            x.last      = (k == CELLS - 1);
            x.value     = '0;
            if (det != 0)
            begin
                // signed division truncates toward zero
                q = (adj[k] <<< (2*FRAC_BITS)) / det;
                if (q > sx(32'h7FFF_FFFF))
                begin
                    x.value = 32'h7FFF_FFFF;
                    x.saturated = 1'b1;
                end
                else if (q < sx(32'h8000_0000))
                begin
                    x.value = 32'h8000_0000;
                    x.saturated = 1'b1;
                end
                else
                    x.value = q[31:0];
            end
            inverse_q.push_back(x);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        inv_entry_t exp_e;
        if (!rst_n)
        begin
            entries_loaded = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    entries_loaded = 0;
                entries[entries_loaded % CELLS] = s_tdata;
                entries_loaded++;
                if (entries_loaded >= CELLS)
                begin
                    entries_loaded = 0;
                    predict_inverse();
                    matrices_done++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected result transfer data=%h user=%b last=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_e = inverse_q.pop_front();
                    if (exp_e.singular)  singular_seen++;
                    if (exp_e.saturated) clipped_seen++;
                    if (m_tdata[31:0] !== exp_e.value || m_tdata[35:32] !== exp_e.index
                        || m_tdata[39:36] !== 4'b0 || m_tuser[0] !== exp_e.singular
                        || m_tuser[1] !== exp_e.saturated || m_tlast !== exp_e.last)
                    begin
                        $display("%0t: mismatch idx %0d exp value=%h sing=%b sat=%b last=%b",
                                 $time, exp_e.index, exp_e.value, exp_e.singular,
                                 exp_e.saturated, exp_e.last);
                        $display("%0t:   actual data=%h sing=%b sat=%b last=%b",
                                 $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = inverse_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
        matrices_done = 0;
        singular_seen = 0;
        clipped_seen = 0;
    end
endmodule

// File: verif/matrix_inverse_4x4_tb.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_tb
// Drives directed and random matrices, with restarts, missing first flags and
// random stalls on both channels, into the 4x4 inverse; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        no_stall;
    int          fail_count;
    int          pending;
    int          matrices_done;
    int          singular_seen;
    int          clipped_seen;
    int          cycle_count;
    int          items_sent;

    localparam int CYCLE_LIMIT = 600000;

    matrix_inverse_4x4 dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    matrix_inverse_4x4_chk chk
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .matrices_done(matrices_done),
        .singular_seen(singular_seen), .clipped_seen(clipped_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        m_tready <= no_stall || ($urandom_range(0, 99) >= 26);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_entry(input logic [31:0] v, input logic f);
        while (!no_stall && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_value(input int mode);
        int sel;
        sel = $urandom_range(0, 99);
        if (mode == 1)
            return $urandom();
        if (sel < 70)
            return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
        else if (sel < 80)
            return 32'h0;
        else if (sel < 85)
            return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else
            return $urandom();
    endfunction

    // flag_mode: 0 flag on entry zero, 1 no flag at all
    task automatic send_matrix(input logic [31:0] m [0:15], input int flag_mode);
        for (int i = 0; i < 16; i++)
            send_entry(m[i], (flag_mode == 0) && (i == 0));
    endtask

    initial
    begin
        logic [31:0] m [0:15];
        int kind;
        int cut;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        no_stall = 1'b0;
        cycle_count = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
        send_matrix(m, 0);
        // all zeros: singular
        for (int i = 0; i < 16; i++)
            m[i] = 32'h0;
        send_matrix(m, 0);
        // tiny diagonal: inverse overflows, sent with no first flag
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? ((i == 5) ? 32'hFFFF_FFFF : 32'h1) : 32'h0;
        send_matrix(m, 1);
        // partial load, then restart with extreme diagonal
        for (int i = 0; i < 5; i++)
            send_entry(32'h1234_5678 + i, i == 0);
        for (int i = 0; i < 16; i++)
            m[i] = (i % 5 == 0) ? ((i < 8) ? 32'h7FFF_FFFF : 32'h8000_0000) : 32'h0;
        send_matrix(m, 0);

        // random part, with one long stretch free of stalls
        while (items_sent < 168)
        begin
            no_stall <= (items_sent > 100 && items_sent < 150);
            kind = $urandom_range(0, 99);
            for (int i = 0; i < 16; i++)
                m[i] = pick_value((kind < 20) ? 1 : 0);
            if (kind >= 85)
                for (int i = 0; i < 4; i++)
                    m[12 + i] = m[i];
            if (kind >= 20 && kind < 27)
            begin
                cut = $urandom_range(1, 15);
                for (int i = 0; i < cut; i++)
                    send_entry(pick_value(1), (i == 0) || ($urandom_range(0, 9) == 0));
            end
            send_matrix(m, (kind >= 27 && kind < 33) ? 1 : 0);
        end
        s_tvalid <= 1'b0;
        no_stall <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);

        $display("sent %0d entries, %0d matrices inverted", items_sent, matrices_done);
        $display("results: %0d singular, %0d clipped", singular_seen, clipped_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: sim.f
hdl/mi4_pkg.sv
hdl/mi4_ctrl.sv
hdl/mi4_datapath.sv
hdl/matrix_inverse_4x4.sv
verif/matrix_inverse_4x4_chk.sv
verif/matrix_inverse_4x4_tb.sv
